// File: sv/bmh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_pkg: shared types and codes for the binary max heap
// Widths, status codes, datapath operation codes and the control/status
// structs passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package bmh_pkg;

    localparam int CAPACITY = 1024;
    localparam int DATA_W   = 32;
    localparam int TOTAL_W  = 11;
    localparam int STATUS_W = 2;
    localparam int OP_W     = 3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic [OP_W-1:0] OP_NONE      = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_START = 3'd1;
    localparam logic [OP_W-1:0] OP_REM_START = 3'd2;
    localparam logic [OP_W-1:0] OP_UP_STEP   = 3'd3;
    localparam logic [OP_W-1:0] OP_DN_LAST   = 3'd4;
    localparam logic [OP_W-1:0] OP_DN_LEFT   = 3'd5;
    localparam logic [OP_W-1:0] OP_DN_STEP   = 3'd6;
    localparam logic [OP_W-1:0] OP_PLACE     = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            out_load;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic cnt_one;
        logic up_gt;
        logic par_root;
        logic dn_go;
        logic pick_leaf;
        logic out_free;
    } sts_t;

endpackage

// File: sv/bmh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_ctrl: heap operation sequencer
// Walks insert (sift-up) and remove (sift-down) through the datapath one
// heap step at a time and hands the finished result to the output stage.
// ----------------------------------------------------------------------------
module bmh_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          action,
    input  bmh_pkg::sts_t sts,
    output bmh_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP      = 3'd1;
    localparam logic [2:0] S_DN_LAST = 3'd2;
    localparam logic [2:0] S_DN_L    = 3'd3;
    localparam logic [2:0] S_DN_R    = 3'd4;
    localparam logic [2:0] S_PLACE   = 3'd5;
    localparam logic [2:0] S_FIN     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.op       = bmh_pkg::OP_NONE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (action == bmh_pkg::ACT_REMOVE)
                    begin
                        cmd.op = bmh_pkg::OP_REM_START;
                        if (sts.empty || sts.cnt_one)
                            state_next = S_FIN;
                        else
                            state_next = S_DN_LAST;
                    end
                    else
                    begin
                        cmd.op = bmh_pkg::OP_INS_START;
                        if (sts.full || sts.empty)
                            state_next = S_FIN;
                        else
                            state_next = S_UP;
                    end
                end
            end
            S_UP:
            begin
                cmd.op = bmh_pkg::OP_UP_STEP;
                if (!sts.up_gt)
                    state_next = S_FIN;
                else if (sts.par_root)
                    state_next = S_PLACE;
                else
                    state_next = S_UP;
            end
            S_DN_LAST:
            begin
                cmd.op     = bmh_pkg::OP_DN_LAST;
                state_next = sts.cnt_one ? S_FIN : S_DN_L;
            end
            S_DN_L:
            begin
                cmd.op     = bmh_pkg::OP_DN_LEFT;
                state_next = S_DN_R;
            end
            S_DN_R:
            begin
                cmd.op = bmh_pkg::OP_DN_STEP;
                if (!sts.dn_go)
                    state_next = S_FIN;
                else if (sts.pick_leaf)
                    state_next = S_PLACE;
                else
                    state_next = S_DN_L;
            end
            S_PLACE:
            begin
                cmd.op     = bmh_pkg::OP_PLACE;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: sv/bmh_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_datapath: heap store, working registers and result register
// One-based heap in a single-port-write, registered-read memory; the root
// is mirrored in a register so the top value needs no read.
// ----------------------------------------------------------------------------
module bmh_datapath #(
    parameter int CAPACITY = bmh_pkg::CAPACITY
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bmh_pkg::cmd_t                       cmd,
    output bmh_pkg::sts_t                       sts,
    input  logic signed [bmh_pkg::DATA_W-1:0]   value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [bmh_pkg::DATA_W-1:0]   removed_value,
    output logic signed [bmh_pkg::DATA_W-1:0]   top_value,
    output logic [bmh_pkg::TOTAL_W-1:0]         element_total,
    output logic [bmh_pkg::STATUS_W-1:0]        status
);

    localparam int AW = $clog2(CAPACITY + 1);
    localparam int DW = bmh_pkg::DATA_W;

    logic signed [DW-1:0] mem [0:CAPACITY];

    logic [AW-1:0]              cnt_reg,     cnt_next;
    logic [AW-1:0]              pos_reg,     pos_next;
    logic signed [DW-1:0]       val_reg,     val_next;
    logic signed [DW-1:0]       left_reg,    left_next;
    logic signed [DW-1:0]       removed_reg, removed_next;
    logic [bmh_pkg::STATUS_W-1:0] status_reg, status_next;
    logic signed [DW-1:0]       root_reg;
    logic signed [DW-1:0]       rd_data_reg;
    logic                       out_valid_reg;
    logic signed [DW-1:0]       out_removed_reg;
    logic signed [DW-1:0]       out_top_reg;
    logic [bmh_pkg::TOTAL_W-1:0]  out_total_reg;
    logic [bmh_pkg::STATUS_W-1:0] out_status_reg;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [DW-1:0] wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;

    logic [AW-1:0]        parent;
    logic [AW:0]          cnt_x;
    logic [AW:0]          left_pos;
    logic [AW:0]          right_pos;
    logic                 right_ok;
    logic                 pick_right;
    logic signed [DW-1:0] pick_val;
    logic [AW-1:0]        pick_pos;
    logic [AW:0]          pick_child;

    always_comb
    begin
        parent     = pos_reg >> 1;
        cnt_x      = {1'b0, cnt_reg};
        left_pos   = {pos_reg, 1'b0};
        right_pos  = {pos_reg, 1'b1};
        right_ok   = right_pos <= cnt_x;
        pick_right = right_ok && (rd_data_reg > left_reg);
        pick_val   = pick_right ? rd_data_reg : left_reg;
        pick_pos   = pick_right ? right_pos[AW-1:0] : left_pos[AW-1:0];
        pick_child = {pick_pos, 1'b0};

        sts.full      = cnt_reg == AW'(CAPACITY);
        sts.empty     = cnt_reg == '0;
        sts.cnt_one   = cnt_reg == AW'(1);
        sts.up_gt     = val_reg > rd_data_reg;
        sts.par_root  = parent == AW'(1);
        sts.dn_go     = pick_val > val_reg;
        sts.pick_leaf = pick_child > cnt_x;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        left_next    = left_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = val_reg;
        rd_en        = 1'b0;
        rd_addr      = parent;
        case (cmd.op)
            bmh_pkg::OP_INS_START:
            begin
                removed_next = '0;
                if (sts.full)
                begin
                    status_next = bmh_pkg::ST_FULL;
                end
                else
                begin
                    status_next = bmh_pkg::ST_OK;
                    cnt_next    = cnt_reg + AW'(1);
                    pos_next    = cnt_reg + AW'(1);
                    val_next    = value;
                    if (sts.empty)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(1);
                        wr_data = value;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = (cnt_reg + AW'(1)) >> 1;
                    end
                end
            end
            bmh_pkg::OP_REM_START:
            begin
                if (sts.empty)
                begin
                    status_next  = bmh_pkg::ST_EMPTY;
                    removed_next = '0;
                end
                else
                begin
                    status_next  = bmh_pkg::ST_OK;
                    removed_next = root_reg;
                    cnt_next     = cnt_reg - AW'(1);
                    pos_next     = AW'(1);
                    if (!sts.cnt_one)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = cnt_reg;
                    end
                end
            end
            bmh_pkg::OP_UP_STEP:
            begin
                wr_en = 1'b1;
                if (sts.up_gt)
                begin
                    wr_data  = rd_data_reg;
                    pos_next = parent;
                    if (!sts.par_root)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = parent >> 1;
                    end
                end
            end
            bmh_pkg::OP_DN_LAST:
            begin
                val_next = rd_data_reg;
                if (sts.cnt_one)
                begin
                    wr_en   = 1'b1;
                    wr_data = rd_data_reg;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = left_pos[AW-1:0];
                end
            end
            bmh_pkg::OP_DN_LEFT:
            begin
                left_next = rd_data_reg;
                rd_en     = right_ok;
                rd_addr   = right_pos[AW-1:0];
            end
            bmh_pkg::OP_DN_STEP:
            begin
                wr_en = 1'b1;
                if (sts.dn_go)
                begin
                    wr_data  = pick_val;
                    pos_next = pick_pos;
                    if (!sts.pick_leaf)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = pick_child[AW-1:0];
                    end
                end
            end
            bmh_pkg::OP_PLACE:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        left_reg    <= left_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
        if (wr_en && (wr_addr == AW'(1)))
            root_reg <= wr_data;
        if (cmd.out_load)
        begin
            out_removed_reg <= removed_reg;
            out_top_reg     <= sts.empty ? '0 : root_reg;
            out_total_reg   <= bmh_pkg::TOTAL_W'(cnt_reg);
            out_status_reg  <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign removed_value = out_removed_reg;
    assign top_value     = out_top_reg;
    assign element_total = out_total_reg;
    assign status        = out_status_reg;

endmodule

// File: sv/binary_max_heap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap: max priority queue on a one-based binary heap
// Input channel (in_valid/in_ready) carries action and value: action 0
// inserts value, action 1 removes the maximum. Each transfer in gives one
// transfer out (out_valid/out_ready) with removed_value, top_value,
// element_total and status (ok, remove on empty, insert on full).
// One item is worked on at a time. The heap store has one write and one
// registered read per cycle, so an insert walks one sift-up level per
// step, and a remove takes two child reads for each sift-down level.
// The result sits in an output register: the next item is taken while it
// waits. If the receiver stalls, a second finished result holds the
// sequencer until the output register frees up.
// Reset empties the heap and drops any pending result; the store needs no
// clearing pass.
// ----------------------------------------------------------------------------
module binary_max_heap #(
    parameter int CAPACITY = bmh_pkg::CAPACITY
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic signed [bmh_pkg::DATA_W-1:0]   value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [bmh_pkg::DATA_W-1:0]   removed_value,
    output logic signed [bmh_pkg::DATA_W-1:0]   top_value,
    output logic [bmh_pkg::TOTAL_W-1:0]         element_total,
    output logic [bmh_pkg::STATUS_W-1:0]        status
);

    bmh_pkg::cmd_t cmd;
    bmh_pkg::sts_t sts;

    bmh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .sts      (sts),
        .cmd      (cmd)
    );

    bmh_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .removed_value (removed_value),
        .top_value     (top_value),
        .element_total (element_total),
        .status        (status)
    );

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == bmh_pkg::ST_EMPTY) |->
            (element_total == '0) && (top_value == '0) && (removed_value == '0))
        else $error("remove on empty heap reported a nonzero field");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == bmh_pkg::ST_FULL) |->
            (element_total == bmh_pkg::TOTAL_W'(CAPACITY)) && (removed_value == '0))
        else $error("insert on full heap reported wrong count or removed value");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transfer accepted while an item is in progress");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for binary_max_heap
// Drives insert and remove transfers with random gaps on the input side and
// random stalls on the output side. A shadow heap predicts every result,
// which is compared field by field in order. The run covers a directed
// opening, random mixes, a fill to full capacity and a drain to empty.
// ----------------------------------------------------------------------------
import bmh_pkg::*;

typedef struct packed {
    logic signed [DATA_W-1:0] removed;
    logic signed [DATA_W-1:0] top;
    logic [TOTAL_W-1:0]       total;
    logic [STATUS_W-1:0]      st;
} heap_result_t;

class max_heap_shadow;
    logic signed [DATA_W-1:0] slots [1:CAPACITY];
    int unsigned              fill;
    heap_result_t             awaited_q[$];
    int unsigned              mismatches;
    int unsigned              inserts;
    int unsigned              removes;
    int unsigned              full_hits;
    int unsigned              empty_hits;
    int unsigned              peak;
    int unsigned              checked;

    function new();
        fill       = 0;
        mismatches = 0;
        inserts    = 0;
        removes    = 0;
        full_hits  = 0;
        empty_hits = 0;
        peak       = 0;
        checked    = 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
        logic signed [DATA_W-1:0] t;
        t        = slots[a];
        slots[a] = slots[b];
        slots[b] = t;
    endfunction

    function void sift_up(int unsigned pos);
        int unsigned parent;
        while (pos > 1)
        begin
            parent = pos >> 1;
            if (!(slots[pos] > slots[parent]))
                break;
            swap_slots(pos, parent);
            pos = parent;
        end
    endfunction

    function void sift_down(int unsigned pos);
        int unsigned left;
        int unsigned pick;
        while (1)
        begin
            left = pos * 2;
            if (left > fill)
                break;
            pick = left;
            if (left + 1 <= fill && slots[left + 1] > slots[left])
                pick = left + 1;
            if (!(slots[pick] > slots[pos]))
                break;
            swap_slots(pos, pick);
            pos = pick;
        end
    endfunction

    function void note_request(logic act, logic signed [DATA_W-1:0] val);
        heap_result_t r;
        r.removed = '0;
        r.st      = ST_OK;
        if (act == ACT_INSERT)
        begin
            inserts++;
            if (fill >= CAPACITY)
            begin
                r.st = ST_FULL;
                full_hits++;
            end
            else
            begin
                fill++;
                slots[fill] = val;
                sift_up(fill);
            end
        end
        else
        begin
            removes++;
            if (fill == 0)
            begin
                r.st = ST_EMPTY;
                empty_hits++;
            end
            else
            begin
                r.removed = slots[1];
                slots[1]  = slots[fill];
                fill--;
                sift_down(1);
            end
        end
        if (fill > peak)
            peak = fill;
        r.top   = (fill > 0) ? slots[1] : '0;
        r.total = fill[TOTAL_W-1:0];
        awaited_q.push_back(r);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] rem, logic signed [DATA_W-1:0] top,
                               logic [TOTAL_W-1:0] total, logic [STATUS_W-1:0] st);
        heap_result_t e;
        checked++;
        if (awaited_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result removed=%0d top=%0d total=%0d status=%0d",
                         $time, rem, top, total, st);
            return;
        end
        e = awaited_q.pop_front();
        if (e.removed !== rem || e.top !== top || e.total !== total || e.st !== st)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result %0d: exp removed=%0d top=%0d total=%0d status=%0d, got removed=%0d top=%0d total=%0d status=%0d",
                         $time, checked, e.removed, e.top, e.total, e.st, rem, top, total, st);
        end
    endfunction

    function int unsigned pending();
        return awaited_q.size();
    endfunction
endclass

module tb_top;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic                      action;
    logic signed [DATA_W-1:0]  value;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [DATA_W-1:0]  removed_value;
    logic signed [DATA_W-1:0]  top_value;
    logic [TOTAL_W-1:0]        element_total;
    logic [STATUS_W-1:0]       status;

    max_heap_shadow            shadow;
    bit                        calm;
    int                        out_stall;
    int unsigned               sent;

    binary_max_heap u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .removed_value (removed_value),
        .top_value     (top_value),
        .element_total (element_total),
        .status        (status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // extremes, a narrow band for ties, otherwise full range
    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: case ($urandom_range(0, 3))
                   0: return 32'sh7fffffff;
                   1: return 32'sh80000000;
                   2: return '0;
                   default: return -1;
               endcase
            1, 2, 3: return $signed($urandom_range(0, 15)) - 8;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic send_item(input logic act, input logic signed [DATA_W-1:0] val);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        value    <= val;
        do
            @(posedge clk);
        while (!in_ready);
        shadow.note_request(act, val);
        sent++;
    endtask

    task automatic run_mix(input int count, input int insert_pct, input bit no_idle);
        calm = no_idle;
        repeat (count)
        begin
            if ($urandom_range(0, 99) < insert_pct)
                send_item(ACT_INSERT, pick_value());
            else
                send_item(ACT_REMOVE, $signed($urandom()));
        end
        calm = 1'b0;
    endtask

    // receiver: stall drawn after each transfer out
    initial
    begin
        out_ready = 1'b0;
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (out_stall > 0)
            begin
                out_ready <= 1'b0;
                out_stall--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            shadow.check_result(removed_value, top_value, element_total, status);
            out_stall = pick_gap();
        end
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d results outstanding", shadow.pending());
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        logic                     dir_act [25];
        logic signed [DATA_W-1:0] dir_val [25];
        int                       i;

        shadow   = new();
        calm     = 1'b0;
        sent     = 0;
        in_valid = 1'b0;
        action   = ACT_INSERT;
        value    = '0;
        rst_n    = 1'b0;

        // remove on empty, extremes, equal values, tie between children
        dir_act = '{ACT_REMOVE,
                    ACT_INSERT, ACT_INSERT, ACT_INSERT, ACT_INSERT, ACT_INSERT, ACT_INSERT,
                    ACT_INSERT,
                    ACT_REMOVE, ACT_REMOVE, ACT_REMOVE, ACT_REMOVE, ACT_REMOVE, ACT_REMOVE,
                    ACT_REMOVE, ACT_REMOVE,
                    ACT_INSERT, ACT_INSERT, ACT_INSERT, ACT_INSERT,
                    ACT_REMOVE, ACT_REMOVE, ACT_REMOVE, ACT_REMOVE, ACT_REMOVE};
        dir_val = '{32'sh5a5a5a5a,
                    32'sh0, 32'sh7fffffff, 32'sh80000000, -32'sd1, 32'sd1, 32'sh7fffffff,
                    32'sh80000000,
                    -32'sd1, 32'sh7fffffff, 32'sh80000000, 32'sh0, 32'sh12345678,
                    32'sh0, 32'sh7fffffff, -32'sd1,
                    32'sd10, 32'sd10, 32'sd10, 32'sd2,
                    32'sh0, -32'sd1, 32'sh7fffffff, 32'sh80000000, 32'sh0};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < 25; i++)
            send_item(dir_act[i], dir_val[i]);

        run_mix(200, 60, 1'b0);
        run_mix(200, 50, 1'b1);
        run_mix(200, 45, 1'b0);

        // fill to capacity, poke at the full boundary, then drain past empty
        while (shadow.fill < CAPACITY)
            send_item(ACT_INSERT, pick_value());
        repeat (3) send_item(ACT_INSERT, pick_value());
        send_item(ACT_REMOVE, $signed($urandom()));
        send_item(ACT_INSERT, pick_value());
        send_item(ACT_INSERT, pick_value());
        while (shadow.fill > 0)
            send_item(ACT_REMOVE, $signed($urandom()));
        repeat (2) send_item(ACT_REMOVE, $signed($urandom()));

        @(negedge clk);
        in_valid <= 1'b0;

        while (shadow.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("run: %0d transfers in, %0d inserts (%0d refused full), %0d removes (%0d on empty)",
                 sent, shadow.inserts, shadow.full_hits, shadow.removes, shadow.empty_hits);
        $display("run: peak occupancy %0d of %0d, %0d results checked",
                 shadow.peak, CAPACITY, shadow.checked);
        if (shadow.mismatches == 0 && shadow.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
sv/bmh_pkg.sv
sv/bmh_ctrl.sv
sv/bmh_datapath.sv
sv/binary_max_heap.sv
tb/tb_top.sv
